[src/mck_pkg.sv]
// Shared types, constants and the character pattern table for the Morse keyer.
`default_nettype none
package mck_pkg;

	// Unit counts of the segment kinds
	localparam logic [2:0] UNITS_DOT        = 3'd1;
	localparam logic [2:0] UNITS_DASH       = 3'd3;
	localparam logic [2:0] UNITS_SYMBOL_GAP = 3'd1;
	localparam logic [2:0] UNITS_LETTER_GAP = 3'd3;
	localparam logic [2:0] UNITS_WORD_EXTRA = 3'd4;

	localparam logic [15:0] UNIT_LENGTH_RESET = 16'd100;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// Pattern code: [7:5] symbol count, [4:0] symbols, first in bit 0, 1 = dash
	localparam logic [7:0] LETTER_CODES [26] = '{
		8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80,
		8'h40, 8'h8E, 8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86,
		8'h8B, 8'h62, 8'h60, 8'h21, 8'h64, 8'h88, 8'h66, 8'h89,
		8'h8D, 8'h83
	};

	localparam logic [7:0] DIGIT_CODES [10] = '{
		8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3,
		8'hA7, 8'hAF
	};

	typedef enum logic [1:0] {
		CH_NONE,
		CH_SYMBOLS,
		CH_SPACE
	} char_kind_t;

	typedef enum logic [1:0] {
		SEG_MARK,
		SEG_SYMGAP,
		SEG_LETGAP,
		SEG_WORD
	} seg_kind_t;

	// Controller to datapath
	typedef struct packed {
		logic      load;
		logic      emit;
		seg_kind_t kind;
		logic [2:0] sym_idx;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		char_kind_t char_kind;
		logic [2:0] sym_count;
	} dp_status_t;

	// Pattern lookup; returns 0 for characters without a pattern
	function automatic logic [7:0] morse_code(input logic [7:0] ch);
		logic [7:0] code;
		code = 8'h00;
		if (ch inside {[8'h61:8'h7A]})
			code = LETTER_CODES[5'(ch - 8'h61)];
		else if (ch inside {[8'h41:8'h5A]})
			code = LETTER_CODES[5'(ch - 8'h41)];
		else if (ch inside {[8'h30:8'h39]})
			code = DIGIT_CODES[4'(ch - 8'h30)];
		return code;
	endfunction

endpackage
`default_nettype wire

[src/mck_dp.sv]
// Keyer datapath: character latch, pattern decode, unit register and segment output.
`default_nettype none
module mck_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [7:0]         char_code,
	input  wire logic               end_of_message,
	input  wire logic               cfg_wr_en,
	input  wire logic [15:0]        cfg_wr_data,
	input  wire mck_pkg::dp_cmd_t   cmd,
	output mck_pkg::dp_status_t     status,
	output logic                    seg_strobe,
	output logic                    lamp_on,
	output logic [17:0]             duration,
	output logic                    last_of_char,
	output logic                    message_end
);
	import mck_pkg::*;

	char_kind_t  char_kind_q;
	logic [7:0]  code_q;
	logic        msg_q;
	logic [15:0] unit_len_q;
	logic        strobe_q;
	logic        lamp_q;
	logic [17:0] dur_q;
	logic        last_q;
	logic        mend_q;

	logic [7:0]  code_d;
	logic [2:0]  units;
	logic        lamp_d;
	logic        last_d;

	// Decode of the incoming character
	always_comb begin
		code_d = morse_code(char_code);
	end

	// Character latch on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_kind_q <= CH_NONE;
		end else if (cmd.load) begin
			if (char_code inside {CHAR_SPACE, CHAR_NEWLINE})
				char_kind_q <= CH_SPACE;
			else if (code_d[7:5] != 3'd0)
				char_kind_q <= CH_SYMBOLS;
			else
				char_kind_q <= CH_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= code_d;
			msg_q  <= end_of_message;
		end
	end

	// Unit length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			unit_len_q <= UNIT_LENGTH_RESET;
		else if (cfg_wr_en)
			unit_len_q <= cfg_wr_data;
	end

	// Segment unit count and flags
	always_comb begin
		units  = UNITS_DOT;
		lamp_d = 1'b0;
		last_d = 1'b0;
		case (cmd.kind)
			SEG_MARK: begin
				lamp_d = 1'b1;
				units  = code_q[cmd.sym_idx] ? UNITS_DASH : UNITS_DOT;
			end
			SEG_SYMGAP: units = UNITS_SYMBOL_GAP;
			SEG_LETGAP: begin
				units  = UNITS_LETTER_GAP;
				last_d = 1'b1;
			end
			SEG_WORD: begin
				units  = UNITS_WORD_EXTRA;
				last_d = 1'b1;
			end
			default: units = UNITS_DOT;
		endcase
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			lamp_q <= lamp_d;
			dur_q  <= 18'(units) * 18'(unit_len_q);
			last_q <= last_d;
			mend_q <= last_d & msg_q;
		end
	end

	assign status.char_kind = char_kind_q;
	assign status.sym_count = code_q[7:5];

	assign seg_strobe   = strobe_q;
	assign lamp_on      = lamp_q;
	assign duration     = dur_q;
	assign last_of_char = last_q;
	assign message_end  = mend_q;

`ifndef SYNTHESIS
	a_mend_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && mend_q |-> last_q)
		else $error("message_end without last_of_char");
	a_lamp_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && lamp_q |-> !last_q)
		else $error("lit segment flagged as last");
	a_strobe_follows_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> strobe_q)
		else $error("emitted segment lost");
`endif

endmodule
`default_nettype wire

[src/mck_ctrl.sv]
// Keyer controller: walks the symbols of one character and sequences the segments.
`default_nettype none
module mck_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire mck_pkg::dp_status_t status,
	output mck_pkg::dp_cmd_t         cmd,
	output logic                     busy
);
	import mck_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t     state_q;
	logic [2:0] sym_idx_q;
	logic       gap_q;
	logic       last_sym;

	assign last_sym = (sym_idx_q == 3'(status.sym_count - 3'd1));

	// Command decode
	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.emit    = 1'b0;
		cmd.kind    = SEG_MARK;
		cmd.sym_idx = sym_idx_q;
		if (state_q == ST_RUN) begin
			case (status.char_kind)
				CH_SPACE: begin
					cmd.emit = 1'b1;
					cmd.kind = SEG_WORD;
				end
				CH_SYMBOLS: begin
					cmd.emit = 1'b1;
					if (!gap_q)
						cmd.kind = SEG_MARK;
					else if (last_sym)
						cmd.kind = SEG_LETGAP;
					else
						cmd.kind = SEG_SYMGAP;
				end
				default: cmd.emit = 1'b0;
			endcase
		end
	end

	// State and symbol position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sym_idx_q <= 3'd0;
			gap_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_RUN;
						sym_idx_q <= 3'd0;
						gap_q     <= 1'b0;
					end
				end
				ST_RUN: begin
					if (status.char_kind != CH_SYMBOLS) begin
						state_q <= ST_IDLE;
					end else if (!gap_q) begin
						gap_q <= 1'b1;
					end else if (last_sym) begin
						state_q <= ST_IDLE;
					end else begin
						gap_q     <= 1'b0;
						sym_idx_q <= sym_idx_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

`ifndef SYNTHESIS
	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cmd.emit)
		else $error("segment emitted while idle");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy && status.char_kind == CH_SYMBOLS |-> sym_idx_q < status.sym_count)
		else $error("symbol index past pattern");
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy && !gap_q && sym_idx_q == 3'd0)
		else $error("run did not start at first symbol");
`endif

endmodule
`default_nettype wire

[src/morse_code_keyer_unit.sv]
// Top level of the International Morse code keyer.
//
// Usage: drive char_code and end_of_message and raise start; the character is
// taken at a clock edge where start is high and busy is low. The block then
// emits key segments, one per cycle, each shown for one cycle with seg_strobe
// high: lamp_on, duration (units times unit_length ticks), last_of_char, and
// message_end on the last segment of a final character.
// A character with n symbols keeps busy high while it yields 2n segments;
// space or newline yields one segment; an unsupported character yields none.
// Each segment is registered in the output beat register before it reaches
// the ports; the sequencer issues one per cycle.
// The next character may be taken at the edge after busy falls.
// The receiver cannot stall: every strobed segment is taken in its cycle.
// cfg_wr_en writes cfg_wr_data to unit_length at the clock edge; write it only while idle (not enforced by the block).
// Reset clears the sequencer and the output strobe and sets unit_length to 100.
`default_nettype none
module morse_code_keyer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_message,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	output logic             seg_strobe,
	output logic             lamp_on,
	output logic [17:0]      duration,
	output logic             last_of_char,
	output logic             message_end
);
	import mck_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer
	mck_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Decode, unit register and output beat
	mck_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_code      (char_code),
		.end_of_message (end_of_message),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.cmd            (cmd),
		.status         (status),
		.seg_strobe     (seg_strobe),
		.lamp_on        (lamp_on),
		.duration       (duration),
		.last_of_char   (last_of_char),
		.message_end    (message_end)
	);

endmodule
`default_nettype wire
